>>> src/cvts_pkg.sv
// Shared types, constants and helper functions for the cue vote trial sequencer.
`timescale 1ns / 1ps

package cvts_pkg;

    localparam logic [15:0] TARGET_FRAMES = 16'd200;
    localparam logic [15:0] RESULT_FRAMES = 16'd75;
    localparam logic [13:0] FULL_SCALE    = 14'd10000;
    localparam logic [11:0] PITCH_SPLIT   = 12'd1800;
    localparam logic [31:0] HASH_MUL      = 32'd2654435761;
    localparam logic [31:0] HASH_ADD      = 32'h9E37_79B9;
    localparam int unsigned HASH_SHIFT    = 13;
    localparam logic [31:0] SEEN_RESET    = 32'hFFFF_FFFF;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned DIV_STEPS = 30;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam logic [1:0] PRED_LEFT  = 2'd0;
    localparam logic [1:0] PRED_RIGHT = 2'd1;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_RESULT = 2'd1;
    localparam logic [1:0] EV_CUE    = 2'd2;

    localparam logic [1:0] REG_DIRECTION_MODE = 2'd0;
    localparam logic [1:0] REG_CYCLE_ROUNDS   = 2'd1;
    localparam logic [1:0] REG_VOTE_SOURCE    = 2'd2;

    typedef enum logic [1:0] {
        RS_IDLE   = 2'd0,
        RS_TARGET = 2'd1,
        RS_RESULT = 2'd3
    } run_state_t;

    typedef enum logic [1:0] {
        CS_READY,
        CS_MUL,
        CS_DIV,
        CS_HASH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        infer_enabled;
        logic [11:0] pitch_tenths;
        logic        infer_ok;
        logic [31:0] infer_count;
        logic [1:0]  infer_pred;
        logic [13:0] infer_confidence;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic        target_dir;
        logic        vote_pred;
        logic        score_pred;
        logic [13:0] score_left;
        logic [13:0] score_right;
        logic [13:0] confidence;
        logic        active;
    } out_item_t;

    typedef struct packed {
        logic        score_pred;
        logic [13:0] score_left;
        logic [13:0] score_right;
    } score_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // The side opposite the vote gets the confidence, the voted side the rest of full scale.
    function automatic score_t make_scores(input logic vote, input logic [13:0] conf);
        score_t      s;
        logic [13:0] other;
        other = FULL_SCALE - conf;
        s.score_left  = vote ? conf : other;
        s.score_right = vote ? other : conf;
        s.score_pred  = (s.score_left >= s.score_right) ? 1'b0 : 1'b1;
        return s;
    endfunction

endpackage

>>> src/cvts_if.sv
// Valid/ready channel interfaces for sequencer commands and results.
`timescale 1ns / 1ps

interface cvts_in_if;
    logic               valid;
    logic               ready;
    cvts_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cvts_out_if;
    logic                valid;
    logic                ready;
    cvts_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/cue_vote_trial_sequencer_core.sv
// Top level of the cue vote trial sequencer with its APB register block.
// Most transactions finish at the accepting edge, where the result is registered.
// A window end in pitch mode runs through the accept, one multiply and 30 steps
// of the restoring divider. A hashed cue is multiplied at the accept, then mixed.
// A new transaction is taken in the ready state once the output slot is free or read.
// rst_n clears all control state asynchronously; registers return to their defaults.
`timescale 1ns / 1ps

module cue_vote_trial_sequencer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cvts_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    cvts_in_if.sink                       req,
    cvts_out_if.source                    rsp
);

    cvts_pkg::ctrl_state_t state_reg, state_next;
    cvts_pkg::run_state_t  run_reg, run_next;

    logic [15:0] frame_reg, frame_next;
    logic [15:0] lvote_reg, lvote_next;
    logic [15:0] rvote_reg, rvote_next;
    logic        dir_reg, dir_next;
    logic [7:0]  lrounds_reg, lrounds_next;
    logic [7:0]  rrounds_reg, rrounds_next;
    logic [31:0] targets_reg, targets_next;
    logic [31:0] seen_reg, seen_next;
    logic [13:0] hconf_reg, hconf_next;

    logic        direction_mode_reg;
    logic [7:0]  cycle_rounds_reg;
    logic        vote_source_reg;

    logic [15:0] maj_reg, maj_next;
    logic [16:0] divisor_reg, divisor_next;
    logic [29:0] dividend_reg, dividend_next;
    logic [16:0] rem_reg, rem_next;
    logic [13:0] quot_reg, quot_next;
    logic [4:0]  step_reg, step_next;
    logic [13:0] hash_reg, hash_next;

    logic                out_valid_reg, out_valid_next;
    cvts_pkg::out_item_t out_data_reg, out_data_next;

    logic apb_write;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    // Register block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_mode_reg <= 1'b0;
            cycle_rounds_reg   <= 8'd3;
            vote_source_reg    <= 1'b0;
        end
        else if (apb_write)
        begin
            unique case (paddr[3:2])
                cvts_pkg::REG_DIRECTION_MODE: direction_mode_reg <= pwdata[0];
                cvts_pkg::REG_CYCLE_ROUNDS:
                begin
                    cycle_rounds_reg <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
                end
                cvts_pkg::REG_VOTE_SOURCE: vote_source_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cvts_pkg::REG_DIRECTION_MODE: prdata = {31'd0, direction_mode_reg};
            cvts_pkg::REG_CYCLE_ROUNDS:   prdata = {24'd0, cycle_rounds_reg};
            cvts_pkg::REG_VOTE_SOURCE:    prdata = {31'd0, vote_source_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign req.ready = (state_reg == cvts_pkg::CS_READY) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvts_pkg::CS_READY;
            run_reg       <= cvts_pkg::RS_IDLE;
            frame_reg     <= 16'd0;
            lvote_reg     <= 16'd0;
            rvote_reg     <= 16'd0;
            dir_reg       <= 1'b0;
            lrounds_reg   <= 8'd0;
            rrounds_reg   <= 8'd0;
            targets_reg   <= 32'd0;
            seen_reg      <= cvts_pkg::SEEN_RESET;
            hconf_reg     <= 14'd0;
            out_valid_reg <= 1'b0;
            step_reg      <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            frame_reg     <= frame_next;
            lvote_reg     <= lvote_next;
            rvote_reg     <= rvote_next;
            dir_reg       <= dir_next;
            lrounds_reg   <= lrounds_next;
            rrounds_reg   <= rrounds_next;
            targets_reg   <= targets_next;
            seen_reg      <= seen_next;
            hconf_reg     <= hconf_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maj_reg      <= maj_next;
        divisor_reg  <= divisor_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        hash_reg     <= hash_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        logic [15:0]      f;
        logic [15:0]      lv;
        logic [15:0]      rv;
        logic             vp;
        logic [13:0]      conf;
        logic [16:0]      total;
        logic [27:0]      hprod;
        logic [13:0]      hmix;
        logic [17:0]      trial;
        logic [16:0]      rem_n;
        logic [13:0]      quot_n;
        logic             defer;
        cvts_pkg::score_t sc;

        state_next    = state_reg;
        run_next      = run_reg;
        frame_next    = frame_reg;
        lvote_next    = lvote_reg;
        rvote_next    = rvote_reg;
        dir_next      = dir_reg;
        lrounds_next  = lrounds_reg;
        rrounds_next  = rrounds_reg;
        targets_next  = targets_reg;
        seen_next     = seen_reg;
        hconf_next    = hconf_reg;
        maj_next      = maj_reg;
        divisor_next  = divisor_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        step_next     = step_reg;
        hash_next     = hash_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        f      = cvts_pkg::sat_inc16(frame_reg);
        lv     = lvote_reg;
        rv     = rvote_reg;
        vp     = 1'b0;
        conf   = 14'd0;
        total  = 17'd0;
        hprod  = targets_reg[13:0] * cvts_pkg::HASH_MUL[13:0];
        hmix   = hash_reg + cvts_pkg::HASH_ADD[13:0];
        trial  = {rem_reg, dividend_reg[29]};
        rem_n  = trial[16:0];
        quot_n = {quot_reg[12:0], 1'b0};
        defer  = 1'b0;
        sc     = '0;

        unique case (state_reg)
            cvts_pkg::CS_READY:
            begin
                if (req.valid && req.ready)
                begin
                    out_data_next = '0;
                    if (req.data.mode == cvts_pkg::MODE_START)
                    begin
                        if (run_reg == cvts_pkg::RS_IDLE)
                        begin
                            lrounds_next = cycle_rounds_reg;
                            rrounds_next = cycle_rounds_reg;
                            targets_next = 32'd0;
                            dir_next     = 1'b0;
                            frame_next   = 16'd0;
                            lvote_next   = 16'd0;
                            rvote_next   = 16'd0;
                            hconf_next   = 14'd0;
                            run_next     = cvts_pkg::RS_TARGET;
                            out_data_next.event_res = cvts_pkg::EV_CUE;
                        end
                    end
                    else if (req.data.mode == cvts_pkg::MODE_STOP)
                    begin
                        run_next = cvts_pkg::RS_IDLE;
                    end
                    else if (req.data.mode == cvts_pkg::MODE_TICK
                             && run_reg != cvts_pkg::RS_IDLE && req.data.infer_enabled)
                    begin
                        frame_next = f;
                        if (run_reg == cvts_pkg::RS_TARGET)
                        begin
                            if (vote_source_reg)
                            begin
                                if (req.data.pitch_tenths > cvts_pkg::PITCH_SPLIT)
                                    rv = cvts_pkg::sat_inc16(rvote_reg);
                                else
                                    lv = cvts_pkg::sat_inc16(lvote_reg);
                            end
                            else if (req.data.infer_ok && req.data.infer_count != seen_reg)
                            begin
                                seen_next = req.data.infer_count;
                                if (req.data.infer_pred == cvts_pkg::PRED_LEFT
                                    || req.data.infer_pred == cvts_pkg::PRED_RIGHT)
                                begin
                                    if (req.data.infer_pred == cvts_pkg::PRED_LEFT)
                                        lv = cvts_pkg::sat_inc16(lvote_reg);
                                    else
                                        rv = cvts_pkg::sat_inc16(rvote_reg);
                                    hconf_next = (req.data.infer_confidence > cvts_pkg::FULL_SCALE)
                                                 ? cvts_pkg::FULL_SCALE
                                                 : req.data.infer_confidence;
                                end
                            end
                            lvote_next = lv;
                            rvote_next = rv;
                            if (f >= cvts_pkg::TARGET_FRAMES)
                            begin
                                vp           = (rv >= lv);
                                targets_next = targets_reg + 32'd1;
                                run_next     = cvts_pkg::RS_RESULT;
                                frame_next   = 16'd0;
                                if (vote_source_reg)
                                begin
                                    // The quotient is produced by the serial divider.
                                    total        = {1'b0, lv} + {1'b0, rv};
                                    divisor_next = (total == 17'd0) ? 17'd1 : total;
                                    maj_next     = vp ? rv : lv;
                                    quot_next    = {13'd0, vp};
                                    state_next   = cvts_pkg::CS_MUL;
                                    defer        = 1'b1;
                                end
                                else
                                begin
                                    conf = hconf_next;
                                    sc   = cvts_pkg::make_scores(vp, conf);
                                    out_data_next.event_res   = cvts_pkg::EV_RESULT;
                                    out_data_next.vote_pred   = vp;
                                    out_data_next.score_pred  = sc.score_pred;
                                    out_data_next.score_left  = sc.score_left;
                                    out_data_next.score_right = sc.score_right;
                                    out_data_next.confidence  = conf;
                                end
                            end
                        end
                        else if (f >= cvts_pkg::RESULT_FRAMES)
                        begin
                            run_next   = cvts_pkg::RS_TARGET;
                            frame_next = 16'd0;
                            lvote_next = 16'd0;
                            rvote_next = 16'd0;
                            hconf_next = 14'd0;
                            out_data_next.event_res = cvts_pkg::EV_CUE;
                            if (direction_mode_reg)
                            begin
                                hash_next  = hprod[13:0];
                                state_next = cvts_pkg::CS_HASH;
                                defer      = 1'b1;
                            end
                            else if (lrounds_reg != 8'd0)
                            begin
                                lrounds_next = lrounds_reg - 8'd1;
                                dir_next     = 1'b0;
                            end
                            else if (rrounds_reg != 8'd0)
                            begin
                                rrounds_next = rrounds_reg - 8'd1;
                                dir_next     = 1'b1;
                            end
                            else
                            begin
                                lrounds_next = cycle_rounds_reg - 8'd1;
                                rrounds_next = cycle_rounds_reg;
                                dir_next     = 1'b0;
                            end
                        end
                    end
                    out_data_next.target_dir = dir_next;
                    out_data_next.active     = (run_next != cvts_pkg::RS_IDLE);
                    if (!defer)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            cvts_pkg::CS_MUL:
            begin
                // The vote flag rides in the low quotient bit until the divide starts.
                dividend_next = {14'd0, maj_reg} * {16'd0, cvts_pkg::FULL_SCALE};
                rem_next      = 17'd0;
                step_next     = 5'(cvts_pkg::DIV_STEPS - 1);
                out_data_next.vote_pred = quot_reg[0];
                quot_next     = 14'd0;
                state_next    = cvts_pkg::CS_DIV;
            end
            cvts_pkg::CS_DIV:
            begin
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_n  = 17'(trial - {1'b0, divisor_reg});
                    quot_n = {quot_reg[12:0], 1'b1};
                end
                rem_next      = rem_n;
                quot_next     = quot_n;
                dividend_next = {dividend_reg[28:0], 1'b0};
                if (step_reg == 5'd0)
                begin
                    sc = cvts_pkg::make_scores(out_data_reg.vote_pred, quot_n);
                    out_data_next.event_res   = cvts_pkg::EV_RESULT;
                    out_data_next.target_dir  = dir_reg;
                    out_data_next.score_pred  = sc.score_pred;
                    out_data_next.score_left  = sc.score_left;
                    out_data_next.score_right = sc.score_right;
                    out_data_next.confidence  = quot_n;
                    out_data_next.active      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cvts_pkg::CS_READY;
                end
                else
                begin
                    step_next = step_reg - 5'd1;
                end
            end
            cvts_pkg::CS_HASH:
            begin
                // The direction is bit 13 xor bit 0 of the hash plus the mix constant.
                dir_next = hmix[cvts_pkg::HASH_SHIFT] ^ hmix[0];
                out_data_next.target_dir = dir_next;
                out_valid_next = 1'b1;
                state_next     = cvts_pkg::CS_READY;
            end
            default: state_next = cvts_pkg::CS_READY;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cvts_pkg::CS_DIV |-> rem_reg < divisor_reg && divisor_reg != 17'd0)
        else $error("divider remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cvts_pkg::CS_MUL |=> state_reg == cvts_pkg::CS_DIV)
        else $error("multiply step not followed by divide");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cvts_pkg::CS_MUL || state_reg == cvts_pkg::CS_DIV)
        |-> run_reg == cvts_pkg::RS_RESULT && !out_valid_reg)
        else $error("divide running outside the result phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.event_res == cvts_pkg::EV_RESULT
        |-> out_data_reg.confidence <= cvts_pkg::FULL_SCALE && out_data_reg.active)
        else $error("window result confidence above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cvts_pkg::CS_HASH |-> run_reg == cvts_pkg::RS_TARGET)
        else $error("hashed cue outside a target window");

endmodule
